/* rtl/core/ptp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron core package
// Shared types, register indexes and saturation helpers of the perceptron core.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam logic REG_FEATURES_IN_USE = 1'b0;
    localparam logic REG_LEARN_RATE      = 1'b1;

    localparam logic [6:0]  FEATURES_IN_USE_RESET = 7'd64;
    localparam logic [15:0] LEARN_RATE_RESET      = 16'd6554;

    typedef struct packed {
        logic       train;
        logic       target;
        logic [7:0] repeats;
        logic       bank;
    } cmd_t;

    typedef struct packed {
        logic init_done;
        logic retire;
    } bk_status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EVAL,
        BK_UPDATE,
        BK_DONE
    } bk_state_t;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] != v[47]) begin
            r = v[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v[40:31] != {10{v[40]}}) begin
            r = v[40] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/perceptron_train_predict_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron train and predict core
// Streams Q8.8 feature elements; each completed vector is either classified
// or used to train the Q16.16 weights and bias with the perceptron rule.
//
// The s_ channel takes one feature element per transfer, at most one per
// cycle. The element that completes a vector (features_in_use elements, zero
// read as one, capped at MAX_FEATURES) also carries action, target and
// repeats. Each completed vector gives exactly one transfer on the m_ channel;
// other elements give none. The back end runs passes through one multiplier
// over a weight memory port. A predict vector, or a train vector with zero
// repeats, takes one pass; a train vector takes one pass per repeat plus one
// more for each repeat that changes the weights.
// Two feature banks let the next vector stream in while the previous one is
// processed; s_ready falls when two vectors are outstanding.
// After reset the back end clears the weights entry by entry, during which
// s_ready stays low; configuration writes are taken at any time.
// A stalled receiver holds the result in the output register, the back end
// then waits, and the front end stops once both banks are in use.
// ----------------------------------------------------------------------------
module perceptron_train_predict_core #(
    parameter int MAX_FEATURES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic signed [15:0] s_feature,
    input  wire logic               s_target,
    input  wire logic [7:0]         s_repeats,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_decision,
    output logic signed [47:0]      m_score,
    output logic                    m_from_training
);

    localparam int CW = $clog2(MAX_FEATURES + 1);
    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int LW = (CW > 7) ? CW : 7;

    logic [6:0]          fiu_reg, fiu_next;
    logic [15:0]         lr_reg, lr_next;
    logic [LW-1:0]       fiu_ext;
    logic [LW-1:0]       len_wide;
    logic [CW-1:0]       vec_len;

    ptp_pkg::bk_status_t bk_status;
    ptp_pkg::cmd_t       push_data;
    ptp_pkg::cmd_t       pop_data;
    logic                push_en;
    logic                pop_en;
    logic                pop_valid;
    logic                fwr_en;
    logic                fwr_bank;
    logic [AW-1:0]       fwr_idx;
    logic signed [15:0]  fwr_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        fiu_next = fiu_reg;
        lr_next  = lr_reg;
        if (cfg_valid) begin
            case (cfg_index)
                ptp_pkg::REG_FEATURES_IN_USE: fiu_next = cfg_data[6:0];
                ptp_pkg::REG_LEARN_RATE:      lr_next  = cfg_data;
                default: begin
                    fiu_next = fiu_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fiu_reg <= ptp_pkg::FEATURES_IN_USE_RESET;
            lr_reg  <= ptp_pkg::LEARN_RATE_RESET;
        end else begin
            fiu_reg <= fiu_next;
            lr_reg  <= lr_next;
        end
    end

    always_comb begin
        fiu_ext = LW'(fiu_reg);
        if (fiu_reg == 7'd0) begin
            len_wide = LW'(1);
        end else if (fiu_ext > LW'(MAX_FEATURES)) begin
            len_wide = LW'(MAX_FEATURES);
        end else begin
            len_wide = fiu_ext;
        end
    end

    assign vec_len = len_wide[CW-1:0];

    ptp_front #(
        .MAX_FEATURES(MAX_FEATURES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_feature (s_feature),
        .s_target  (s_target),
        .s_repeats (s_repeats),
        .vec_len   (vec_len),
        .bk_status (bk_status),
        .fwr_en    (fwr_en),
        .fwr_bank  (fwr_bank),
        .fwr_idx   (fwr_idx),
        .fwr_data  (fwr_data),
        .push_en   (push_en),
        .push_data (push_data)
    );

    ptp_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_data (push_data),
        .pop_en    (pop_en),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    ptp_back #(
        .MAX_FEATURES(MAX_FEATURES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .vec_len         (vec_len),
        .learn_rate      (lr_reg),
        .fwr_en          (fwr_en),
        .fwr_bank        (fwr_bank),
        .fwr_idx         (fwr_idx),
        .fwr_data        (fwr_data),
        .pop_valid       (pop_valid),
        .pop_data        (pop_data),
        .pop_en          (pop_en),
        .bk_status       (bk_status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_decision      (m_decision),
        .m_score         (m_score),
        .m_from_training (m_from_training)
    );

endmodule
`default_nettype wire

/* rtl/core/ptp_cmd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron command queue
// Two-entry queue of completed-vector commands between front and back ends.
// ----------------------------------------------------------------------------
module ptp_cmd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_en,
    input  wire ptp_pkg::cmd_t push_data,
    input  wire logic          pop_en,
    output logic               pop_valid,
    output ptp_pkg::cmd_t      pop_data
);

    ptp_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_en} - {1'b0, pop_en};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ptp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron front end
// Accepts feature elements, writes them into the free feature bank and issues
// a command when an element completes a vector.
// ----------------------------------------------------------------------------
module ptp_front #(
    parameter  int MAX_FEATURES = 64,
    localparam int CW = $clog2(MAX_FEATURES + 1),
    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic signed [15:0] s_feature,
    input  wire logic               s_target,
    input  wire logic [7:0]         s_repeats,
    input  wire logic [CW-1:0]      vec_len,
    input  wire ptp_pkg::bk_status_t bk_status,
    output logic                    fwr_en,
    output logic                    fwr_bank,
    output logic [AW-1:0]           fwr_idx,
    output logic signed [15:0]      fwr_data,
    output logic                    push_en,
    output ptp_pkg::cmd_t           push_data
);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          bank_reg, bank_next;
    logic [1:0]    outst_reg, outst_next;
    logic          take;
    logic [CW-1:0] cnt_inc;
    logic          last;

    assign s_ready = bk_status.init_done && (outst_reg != 2'd2);
    assign take    = s_valid && s_ready;
    assign cnt_inc = cnt_reg + CW'(1);
    assign last    = (cnt_inc >= vec_len);

    assign fwr_en   = take;
    assign fwr_bank = bank_reg;
    assign fwr_idx  = cnt_reg[AW-1:0];
    assign fwr_data = s_feature;

    assign push_en           = take && last;
    assign push_data.train   = s_action;
    assign push_data.target  = s_target;
    assign push_data.repeats = s_repeats;
    assign push_data.bank    = bank_reg;

    always_comb begin
        cnt_next   = cnt_reg;
        bank_next  = bank_reg;
        if (take) begin
            cnt_next = last ? '0 : cnt_inc;
        end
        if (push_en) begin
            bank_next = ~bank_reg;
        end
        outst_next = outst_reg + {1'b0, push_en} - {1'b0, bk_status.retire};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            bank_reg  <= 1'b0;
            outst_reg <= 2'd0;
        end else begin
            cnt_reg   <= cnt_next;
            bank_reg  <= bank_next;
            outst_reg <= outst_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ptp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron back end
// Holds the feature banks, weights and bias, runs evaluation and update passes
// through one shared multiplier and drives the result register.
// ----------------------------------------------------------------------------
module ptp_back #(
    parameter  int MAX_FEATURES = 64,
    localparam int CW = $clog2(MAX_FEATURES + 1),
    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [CW-1:0]      vec_len,
    input  wire logic [15:0]        learn_rate,
    input  wire logic               fwr_en,
    input  wire logic               fwr_bank,
    input  wire logic [AW-1:0]      fwr_idx,
    input  wire logic signed [15:0] fwr_data,
    input  wire logic               pop_valid,
    input  wire ptp_pkg::cmd_t      pop_data,
    output logic                    pop_en,
    output ptp_pkg::bk_status_t     bk_status,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_decision,
    output logic signed [47:0]      m_score,
    output logic                    m_from_training
);

    logic signed [15:0] fmem [2][MAX_FEATURES];
    logic signed [31:0] wmem [MAX_FEATURES];

    ptp_pkg::bk_state_t state_reg, state_next;
    ptp_pkg::cmd_t      cmd_reg, cmd_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic [7:0]         reps_reg, reps_next;
    logic signed [47:0] acc_reg, acc_next;
    logic signed [31:0] bias_reg, bias_next;
    logic               v1_reg, v2_reg;
    logic [AW-1:0]      idx1_reg, idx2_reg;
    logic signed [15:0] f_rd_reg;
    logic signed [31:0] w_rd_reg, w2_reg;
    logic signed [47:0] prod_reg;
    logic               m_valid_reg, m_valid_next;
    logic               dec_reg;
    logic signed [47:0] score_reg;
    logic               from_train_reg;

    logic               updating;
    logic               issue;
    logic               pass_done;
    logic               eval_dec;
    logic               out_load;
    logic signed [31:0] mul_a;
    logic signed [47:0] mul_p;
    logic signed [39:0] term;
    logic signed [48:0] acc_sum;
    logic signed [40:0] w_sum;
    logic signed [40:0] b_sum;
    logic signed [40:0] lr_ext;
    logic               wr_en;
    logic [AW-1:0]      wr_idx;
    logic signed [31:0] wr_data;

    assign updating  = (state_reg == ptp_pkg::BK_UPDATE);
    assign issue     = ((state_reg == ptp_pkg::BK_EVAL) || updating) && (iss_reg != vec_len);
    assign pass_done = (iss_reg == vec_len) && !v1_reg && !v2_reg;
    assign eval_dec  = ~acc_reg[47];

    assign lr_ext  = 41'($signed({1'b0, learn_rate}));
    assign mul_a   = updating ? $signed({16'h0000, learn_rate}) : w_rd_reg;
    assign mul_p   = mul_a * f_rd_reg;
    assign term    = prod_reg[47:8];
    assign acc_sum = 49'(acc_reg) + 49'(term);
    assign w_sum   = cmd_reg.target ? (41'(w2_reg) + 41'(term)) : (41'(w2_reg) - 41'(term));
    assign b_sum   = cmd_reg.target ? (41'(bias_reg) + lr_ext) : (41'(bias_reg) - lr_ext);

    assign wr_en   = (state_reg == ptp_pkg::BK_CLEAR) || (v2_reg && updating);
    assign wr_idx  = (state_reg == ptp_pkg::BK_CLEAR) ? clr_reg : idx2_reg;
    assign wr_data = (state_reg == ptp_pkg::BK_CLEAR) ? '0 : ptp_pkg::sat32(w_sum);

    assign bk_status.init_done = (state_reg != ptp_pkg::BK_CLEAR);
    assign bk_status.retire    = out_load;

    assign m_valid         = m_valid_reg;
    assign m_decision      = dec_reg;
    assign m_score         = score_reg;
    assign m_from_training = from_train_reg;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        clr_next   = clr_reg;
        iss_next   = issue ? (iss_reg + CW'(1)) : iss_reg;
        reps_next  = reps_reg;
        bias_next  = bias_reg;
        acc_next   = (v2_reg && (state_reg == ptp_pkg::BK_EVAL)) ? ptp_pkg::sat48(acc_sum)
                                                                  : acc_reg;
        pop_en     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ptp_pkg::BK_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_FEATURES - 1)) begin
                    state_next = ptp_pkg::BK_IDLE;
                end
            end
            ptp_pkg::BK_IDLE: begin
                if (pop_valid) begin
                    pop_en     = 1'b1;
                    cmd_next   = pop_data;
                    reps_next  = pop_data.train ? pop_data.repeats : 8'd0;
                    iss_next   = '0;
                    acc_next   = 48'(bias_reg);
                    state_next = ptp_pkg::BK_EVAL;
                end
            end
            ptp_pkg::BK_EVAL: begin
                if (pass_done) begin
                    if (reps_reg == 8'd0) begin
                        state_next = ptp_pkg::BK_DONE;
                    end else if (cmd_reg.target == eval_dec) begin
                        reps_next = reps_reg - 8'd1;
                        if (reps_reg == 8'd1) begin
                            state_next = ptp_pkg::BK_DONE;
                        end else begin
                            iss_next = '0;
                            acc_next = 48'(bias_reg);
                        end
                    end else begin
                        bias_next  = ptp_pkg::sat32(b_sum);
                        iss_next   = '0;
                        state_next = ptp_pkg::BK_UPDATE;
                    end
                end
            end
            ptp_pkg::BK_UPDATE: begin
                if (pass_done) begin
                    reps_next = reps_reg - 8'd1;
                    if (reps_reg == 8'd1) begin
                        state_next = ptp_pkg::BK_DONE;
                    end else begin
                        iss_next   = '0;
                        acc_next   = 48'(bias_reg);
                        state_next = ptp_pkg::BK_EVAL;
                    end
                end
            end
            ptp_pkg::BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ptp_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = ptp_pkg::BK_IDLE;
            end
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptp_pkg::BK_CLEAR;
            clr_reg     <= '0;
            iss_reg     <= '0;
            reps_reg    <= 8'd0;
            bias_reg    <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            iss_reg     <= iss_next;
            reps_reg    <= reps_next;
            bias_reg    <= bias_next;
            v1_reg      <= issue;
            v2_reg      <= v1_reg;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        acc_reg  <= acc_next;
        idx1_reg <= iss_reg[AW-1:0];
        idx2_reg <= idx1_reg;
        w2_reg   <= w_rd_reg;
        prod_reg <= mul_p;
        if (out_load) begin
            dec_reg        <= eval_dec;
            score_reg      <= acc_reg;
            from_train_reg <= cmd_reg.train;
        end
    end

    always_ff @(posedge aclk) begin
        if (fwr_en) begin
            fmem[fwr_bank][fwr_idx] <= fwr_data;
        end
        if (issue) begin
            f_rd_reg <= fmem[cmd_reg.bank][iss_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wmem[wr_idx] <= wr_data;
        end
        if (issue) begin
            w_rd_reg <= wmem[iss_reg[AW-1:0]];
        end
    end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perceptron train and predict core testbench
// Streams feature elements into the core under several vector lengths and
// learning rates, keeps its own copy of the weights, bias and feature buffer,
// and checks decision, score and from_training of every result it predicts.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_FEATURES = 64;
    localparam longint SCORE_TOP = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SCORE_BOTTOM = -SCORE_TOP - 1;
    localparam int PHASES = 12;
    localparam int PHASE_ELEMENTS = 92;

    typedef struct {
        logic               action;
        logic signed [15:0] feature;
        logic               target;
        logic [7:0]         repeats;
    } element_t;

    typedef struct {
        logic               decision;
        logic signed [47:0] score;
        logic               from_training;
    } verdict_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = ptp_pkg::REG_FEATURES_IN_USE;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = 1'b0;
    logic signed [15:0] s_feature = '0;
    logic               s_target = 1'b0;
    logic [7:0]         s_repeats = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_decision;
    logic signed [47:0] m_score;
    logic               m_from_training;

    element_t pending_elements[$];
    verdict_t awaited_verdicts[$];

    logic signed [15:0] feature_shadow [MAX_FEATURES] = '{default: '0};
    logic signed [31:0] weight_shadow [MAX_FEATURES] = '{default: '0};
    logic signed [31:0] bias_shadow = '0;
    int unsigned        elements_held = 0;
    logic [6:0]         length_reg = ptp_pkg::FEATURES_IN_USE_RESET;
    logic [15:0]        rate_reg = ptp_pkg::LEARN_RATE_RESET;

    int     s_idle_pct = 0;
    int     m_stall_pct = 0;
    int     mismatch_count = 0;
    longint cycle_count = 0;
    longint cycle_budget = 20000;

    int phase_len [PHASES] = '{2, 64, 0, 5, 127, 1, 8, 3, 16, 1, 4, 7};
    int phase_rate [PHASES] = '{6554, 65535, 0, -1, 1, 65535, -1, 300, -1, 0, 40000, -1};

    perceptron_train_predict_core #(
        .MAX_FEATURES(MAX_FEATURES)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_feature(s_feature),
        .s_target(s_target),
        .s_repeats(s_repeats),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_decision(m_decision),
        .m_score(m_score),
        .m_from_training(m_from_training)
    );

    always #5 aclk = ~aclk;

    function automatic longint clamp_score(input longint v);
        if (v > SCORE_TOP) return SCORE_TOP;
        if (v < SCORE_BOTTOM) return SCORE_BOTTOM;
        return v;
    endfunction

    function automatic logic signed [31:0] clamp_word(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint weighted_score(input int n);
        longint acc;
        longint prod;
        acc = longint'(bias_shadow);
        for (int i = 0; i < n; i++) begin
            prod = longint'(weight_shadow[i]) * longint'(feature_shadow[i]);
            acc = clamp_score(acc + (prod >>> 8));
        end
        return acc;
    endfunction

    // Buffers one element; a completed vector is scored and, for training,
    // put through the perceptron rule once per repeat.
    function automatic void perceptron_absorb(input element_t e);
        int       n;
        int       err;
        longint   sc;
        longint   rate;
        longint   step;
        longint   w;
        verdict_t v;
        n = (length_reg == 0) ? 1 : (length_reg > MAX_FEATURES) ? MAX_FEATURES : length_reg;
        if (elements_held < MAX_FEATURES) feature_shadow[elements_held] = e.feature;
        elements_held++;
        if (elements_held < n) return;
        elements_held = 0;
        rate = longint'(rate_reg);
        sc = weighted_score(n);
        if (e.action) begin
            for (int r = 0; r < e.repeats; r++) begin
                sc = weighted_score(n);
                err = int'(e.target) - ((sc >= 0) ? 1 : 0);
                if (err != 0) begin
                    bias_shadow = clamp_word(longint'(bias_shadow) + ((err > 0) ? rate : -rate));
                    for (int i = 0; i < n; i++) begin
                        step = (rate * longint'(feature_shadow[i])) >>> 8;
                        w = longint'(weight_shadow[i]);
                        weight_shadow[i] = clamp_word((err > 0) ? w + step : w - step);
                    end
                end
            end
        end
        v.decision = (sc >= 0);
        v.score = sc[47:0];
        v.from_training = e.action;
        awaited_verdicts.push_back(v);
    endfunction

    // Queues count elements; the last one carries the given control fields
    // when it closes a vector, all others carry random ones.
    function automatic void queue_vector(input int count, input int length, input bit closes,
                                         input logic action, input logic target,
                                         input logic [7:0] repeats,
                                         input logic signed [15:0] feature, input bit scatter);
        element_t e;
        for (int i = 0; i < count; i++) begin
            if (!scatter) begin
                e.feature = feature;
            end else if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: e.feature = 16'sh7FFF;
                    1: e.feature = 16'sh8000;
                    2: e.feature = 16'sh0000;
                    default: e.feature = 16'shFFFF;
                endcase
            end else begin
                e.feature = 16'($urandom);
            end
            if (closes && i == count - 1) begin
                e.action = action;
                e.target = target;
                e.repeats = repeats;
            end else begin
                e.action = 1'($urandom);
                e.target = 1'($urandom);
                e.repeats = 8'($urandom);
            end
            pending_elements.push_back(e);
        end
        cycle_budget += 40 * count;
        if (closes)
            cycle_budget += 4 * ((1 + 2 * (action ? repeats : 0)) * (length + 3) + 40);
    endfunction

    function automatic logic [7:0] draw_repeats();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return 8'($urandom_range(0, 255));
        if (roll < 15) return 8'd0;
        return 8'($urandom_range(1, 4));
    endfunction

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cycle_budget += 50;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == ptp_pkg::REG_FEATURES_IN_USE) length_reg = data[6:0];
        else rate_reg = data;
    endtask

    task automatic wait_until_settled();
        cycle_budget += 400;
        while (pending_elements.size() != 0 || s_valid || awaited_verdicts.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : element_driver
        element_t nxt;
        element_t taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken.action = s_action;
                taken.feature = s_feature;
                taken.target = s_target;
                taken.repeats = s_repeats;
                perceptron_absorb(taken);
            end
            if (!s_valid || s_ready) begin
                if (pending_elements.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                    nxt = pending_elements.pop_front();
                    s_valid <= 1'b1;
                    s_action <= nxt.action;
                    s_feature <= nxt.feature;
                    s_target <= nxt.target;
                    s_repeats <= nxt.repeats;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_verdicts.size() == 0) begin
                    $error("result transfer with no result outstanding");
                    mismatch_count++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (m_decision !== want.decision) begin
                        $error("decision: expected %0d, got %0d", want.decision, m_decision);
                        mismatch_count++;
                    end
                    if (m_score !== want.score) begin
                        $error("score: expected %0d, got %0d", want.score, m_score);
                        mismatch_count++;
                    end
                    if (m_from_training !== want.from_training) begin
                        $error("from_training: expected %0d, got %0d",
                               want.from_training, m_from_training);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= m_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > cycle_budget) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int n_eff;
        int issued;
        int carried;
        int first;
        int rate;
        carried = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // A length of zero behaves as one element per vector.
        write_reg(ptp_pkg::REG_FEATURES_IN_USE, 16'd0);
        write_reg(ptp_pkg::REG_LEARN_RATE, 16'hFFFF);
        queue_vector(1, 1, 1'b1, 1'b0, 1'b0, 8'd0, 16'sh7FFF, 1'b0);
        queue_vector(1, 1, 1'b1, 1'b1, 1'b0, 8'd1, 16'sh7FFF, 1'b0);
        queue_vector(1, 1, 1'b1, 1'b1, 1'b1, 8'd255, 16'sh8000, 1'b0);
        queue_vector(1, 1, 1'b1, 1'b1, 1'b1, 8'd0, 16'sh0001, 1'b0);
        queue_vector(1, 1, 1'b1, 1'b0, 1'b1, 8'd255, 16'sh8000, 1'b0);
        queue_vector(1, 1, 1'b1, 1'b1, 1'b0, 8'd7, 16'shFFFF, 1'b0);
        wait_until_settled();

        write_reg(ptp_pkg::REG_FEATURES_IN_USE, 16'd3);
        write_reg(ptp_pkg::REG_LEARN_RATE, 16'd1000);
        queue_vector(3, 3, 1'b1, 1'b0, 1'b0, 8'd0, '0, 1'b1);
        queue_vector(3, 3, 1'b1, 1'b1, 1'b1, 8'd3, 16'sh7FFF, 1'b0);
        queue_vector(3, 3, 1'b1, 1'b1, 1'b0, 8'd2, 16'sh8000, 1'b0);
        queue_vector(2, 3, 1'b0, 1'b0, 1'b0, 8'd0, '0, 1'b1);
        wait_until_settled();

        // Shrinking the length mid-vector completes it on the next element.
        write_reg(ptp_pkg::REG_FEATURES_IN_USE, 16'd1);
        queue_vector(1, 1, 1'b1, 1'b1, 1'b1, 8'd5, '0, 1'b1);
        queue_vector(1, 1, 1'b1, 1'b0, 1'b0, 8'd0, '0, 1'b1);
        wait_until_settled();

        write_reg(ptp_pkg::REG_FEATURES_IN_USE, 16'd2);
        queue_vector(1, 2, 1'b0, 1'b0, 1'b0, 8'd0, '0, 1'b1);
        wait_until_settled();
        write_reg(ptp_pkg::REG_FEATURES_IN_USE, 16'd4);
        queue_vector(3, 4, 1'b1, 1'b1, 1'b0, 8'd3, '0, 1'b1);
        wait_until_settled();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                1: begin s_idle_pct = 73; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 73; end
                default: begin s_idle_pct = 13; m_stall_pct = 13; end
            endcase
            rate = (phase_rate[p] < 0) ? int'($urandom_range(0, 65535)) : phase_rate[p];
            write_reg(ptp_pkg::REG_FEATURES_IN_USE, {9'($urandom), 7'(phase_len[p])});
            write_reg(ptp_pkg::REG_LEARN_RATE, 16'(rate));
            n_eff = (phase_len[p] == 0) ? 1 :
                    (phase_len[p] > MAX_FEATURES) ? MAX_FEATURES : phase_len[p];
            issued = 0;
            if (carried != 0) begin
                first = (carried >= n_eff) ? 1 : n_eff - carried;
                queue_vector(first, n_eff, 1'b1, 1'($urandom), 1'($urandom), draw_repeats(),
                             '0, 1'b1);
                issued += first;
                carried = 0;
            end
            while (issued < PHASE_ELEMENTS) begin
                queue_vector(n_eff, n_eff, 1'b1, 1'($urandom), 1'($urandom), draw_repeats(),
                             '0, 1'b1);
                issued += n_eff;
            end
            if (p < PHASES - 1 && n_eff > 1 && $urandom_range(0, 2) == 0) begin
                carried = $urandom_range(1, n_eff - 1);
                queue_vector(carried, n_eff, 1'b0, 1'b0, 1'b0, 8'd0, '0, 1'b1);
            end
            wait_until_settled();
        end

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ptp_pkg.sv
rtl/core/ptp_cmd_queue.sv
rtl/core/ptp_front.sv
rtl/core/ptp_back.sv
rtl/core/perceptron_train_predict_core.sv
tb/sv/tb_top.sv
